// File: rtl/core/rcpmf_pkg.sv
// Shared widths, constants and controller/datapath interface types for the pulse mode filter.
package rcpmf_pkg;

    // Field widths
    localparam int VALUE_W = 12;
    localparam int COUNT_W = 7;
    localparam int TOL_W   = 8;
    localparam int CH_W    = 3;
    localparam int WORD_W  = VALUE_W + COUNT_W;

    // Arithmetic constants
    localparam int COUNT_MAX  = 127;
    localparam int TOL_SCALE  = 1000;
    localparam int PROD_W     = 22;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

    // Request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF    = 10;
    localparam int NUM_CHANNELS_DEF = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic sweep;
        logic idx_clr;
        logic add_wr;
        logic clr_wr;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic ch_ok;
        logic is_read;
        logic scan_done;
    } sts_t;

endpackage

// File: rtl/core/rcpmf_dp.sv
// Datapath of the pulse mode filter: slot memory, scan evaluation, tolerance register, result.
module rcpmf_dp
    import rcpmf_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               req_type,
    input  logic [CH_W-1:0]    channel,
    input  logic [VALUE_W-1:0] sample_value,
    input  logic               cfg_valid,
    input  logic [TOL_W-1:0]   cfg_data,
    output logic [VALUE_W-1:0] selected_value
);

    localparam int DEPTH  = NUM_SLOTS * NUM_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = $clog2(NUM_SLOTS + 1);

    // Slot memory: value in the upper bits, hit count in the lower bits
    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;

    logic [TOL_W-1:0]   tol_reg;
    logic               req_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [VALUE_W-1:0] sample_reg;
    logic [ADDR_W-1:0]  base_reg;

    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [SLOT_W-1:0]  ev_idx_reg;

    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  hit_idx_reg;
    logic [VALUE_W-1:0] hit_val_reg;
    logic [COUNT_W-1:0] hit_cnt_reg;
    logic               empty_reg, empty_next;
    logic [SLOT_W-1:0]  empty_idx_reg;
    logic [COUNT_W-1:0] best_reg;
    logic [VALUE_W-1:0] sel_reg;
    logic [VALUE_W-1:0] out_reg;

    logic               issue;
    logic               eval;
    logic [VALUE_W-1:0] ev_val;
    logic [COUNT_W-1:0] ev_cnt;
    logic [VALUE_W-1:0] diff;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic               match;
    logic [COUNT_W-1:0] cnt_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;

    // Decode the returned slot word
    assign ev_val = rd_data_reg[WORD_W-1:COUNT_W];
    assign ev_cnt = rd_data_reg[COUNT_W-1:0];
    assign diff   = (sample_reg > ev_val) ? (sample_reg - ev_val) : (ev_val - sample_reg);
    assign lhs    = PROD_W'(diff) * PROD_W'(TOL_SCALE);
    assign rhs    = PROD_W'(tol_reg) * PROD_W'(ev_val);
    assign match  = lhs < rhs;
    assign cnt_inc = (hit_cnt_reg == COUNT_W'(COUNT_MAX)) ? hit_cnt_reg
                                                          : hit_cnt_reg + 1'b1;

    // Read issue and evaluation timing
    assign issue   = (cmd.scan || cmd.sweep) && (idx_reg < IDX_W'(NUM_SLOTS));
    assign eval    = cmd.scan && pend_reg;
    assign rd_addr = base_reg + ADDR_W'(idx_reg);

    // Status back to the controller
    assign sts.clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign sts.ch_ok     = (32'(ch_reg) < NUM_CHANNELS);
    assign sts.is_read   = (req_reg == REQ_READ);
    assign sts.scan_done = (idx_reg == IDX_W'(NUM_SLOTS)) && !pend_reg;

    assign selected_value = out_reg;

    // Select the single write port: clearing pass, add update, read sweep
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.add_wr)
        begin
            if (hit_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = base_reg + ADDR_W'(hit_idx_reg);
                wr_data = {hit_val_reg, cnt_inc};
            end
            else if (empty_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = base_reg + ADDR_W'(empty_idx_reg);
                wr_data = {sample_reg, COUNT_W'(1)};
            end
        end
        else if (cmd.sweep && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = base_reg + ADDR_W'(ev_idx_reg);
            wr_data = {((ev_val == sel_reg) ? ev_val : VALUE_W'(0)), COUNT_W'(0)};
        end
    end

    // Memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next values of the control counters and flags
    always_comb
    begin
        clr_addr_next = cmd.clr_wr ? clr_addr_reg + 1'b1 : clr_addr_reg;
        idx_next      = idx_reg;
        pend_next     = issue;
        hit_next      = hit_reg;
        empty_next    = empty_reg;
        if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.load || cmd.idx_clr)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        if (eval && (req_reg == REQ_ADD))
        begin
            if (match)
            begin
                hit_next = 1'b1;
            end
            if (ev_val == '0)
            begin
                empty_next = 1'b1;
            end
        end
        if (cmd.load)
        begin
            hit_next   = 1'b0;
            empty_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= TOL_RESET;
            clr_addr_reg <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end
            clr_addr_reg <= clr_addr_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            empty_reg    <= empty_next;
        end
    end

    // Capture the item and record scan results
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ev_idx_reg <= SLOT_W'(idx_reg);
        end
        if (cmd.load)
        begin
            req_reg    <= req_type;
            ch_reg     <= channel;
            sample_reg <= sample_value;
            base_reg   <= ADDR_W'(32'(channel) * NUM_SLOTS);
            best_reg   <= '0;
            sel_reg    <= '0;
        end
        else if (eval)
        begin
            if ((req_reg == REQ_ADD) && match && !hit_reg)
            begin
                hit_idx_reg <= ev_idx_reg;
                hit_val_reg <= ev_val;
                hit_cnt_reg <= ev_cnt;
            end
            if ((req_reg == REQ_ADD) && (ev_val == '0) && !empty_reg)
            begin
                empty_idx_reg <= ev_idx_reg;
            end
            if ((req_reg == REQ_READ) && (ev_cnt > best_reg))
            begin
                best_reg <= ev_cnt;
                sel_reg  <= ev_val;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= sel_reg;
        end
    end

endmodule

// File: rtl/core/rcpmf_ctrl.sv
// Controller of the pulse mode filter: sequences clearing, slot scans, updates and results.
module rcpmf_ctrl
    import rcpmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_ADD_WR = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       res_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_free  = !out_valid_reg || out_ready;

    // Advance the sequencer and raise commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.ch_ok)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.is_read)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.is_read)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_ADD_WR;
                    end
                end
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (res_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set the result flag on load, drop it once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/rc_pulse_mode_filter_top.sv
// Top level of the pulse mode filter: controller and datapath joined by command and status.
//
// Requests arrive as beats on the in_valid/in_ready channel: req_type selects an add
// (sample_value goes into the channel's slot table) or a read (the channel's mode is
// returned as one beat on out_valid/out_ready and the table is reduced to it).
// The tolerance register is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high and writes are meant for idle periods.
// An add frees the input once its slot walk and its write are done; a read returns its
// result after a second walk, the sweep. Each slot is read once per pass through the single
// read port of the slot memory, so the slot walk sets how long an add or a read takes.
// A request on an unused channel skips the slot walk: an add returns to idle from decode,
// and a read goes straight to its result, which is always 0.
// After reset the slot memory is cleared one entry a cycle, all NUM_CHANNELS * NUM_SLOTS
// entries, with in_ready low; the tolerance register returns to 3 at once.
// The result sits in an output register: the next request is taken while it waits, and a
// following read holds its result back until the receiver has taken the earlier beat.
module rc_pulse_mode_filter_top
    import rcpmf_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [CH_W-1:0]    channel,
    input  logic [VALUE_W-1:0] sample_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] selected_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOL_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rcpmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rcpmf_dp #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .channel        (channel),
        .sample_value   (sample_value),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .selected_value (selected_value)
    );

endmodule
